// ===== hw/rtl/modbus_meter_response_checker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the meter response checker
// Concurrent checks, clocked on the rising edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MODBUS_METER_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_METER_RESPONSE_CHECKER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds too.
`define MMRC_AST_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("mmrc: same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define MMRC_AST_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("mmrc: next-cycle check failed");

`endif

// ===== hw/rtl/mmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mmrc_pkg
// Constants and types shared by the meter response checker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmrc_pkg;

	localparam int FRAME_BYTES = 25;
	localparam int CRC_SPAN    = 23;
	localparam int CNT_W       = 5;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic REQ_BYTE    = 1'b0;
	localparam logic REQ_TIMEOUT = 1'b1;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_CRC     = 2'd1;
	localparam status_t ST_TIMEOUT = 2'd2;

	typedef struct packed {
		logic       step;
		logic       req_type;
		logic [7:0] rx_byte;
	} frame_in_t;

	typedef struct packed {
		status_t     status;
		logic        reading_valid;
		logic [15:0] voltage_raw;
		logic [31:0] current_raw;
		logic [31:0] power_raw;
		logic [31:0] energy_raw;
		logic [15:0] frequency_raw;
		logic [15:0] pf_raw;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/modbus_meter_response_checker.sv =====
// ----------------------------------------------------------------------------
// modbus_meter_response_checker
// Checks a 25-byte Modbus RTU meter reply and emits its raw readings.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): one request per UART byte
//   (req_type 0, rx_byte) or a reply timeout (req_type 1).
//   Response channel (rsp_valid / rsp_stall): one response per completed
//   frame (byte 24 received) or per timeout; other bytes give none.
//   A response is registered: the input register takes the request that
//   causes it, and the result register takes the response when that
//   request advances.
//   Throughput: one request per cycle unless req_stall is high; the CRC
//   update is eight unrolled shift steps from the input register to crc_q.
//   Status 0 = frame valid with readings, 1 = CRC mismatch, 2 = timeout;
//   readings are zero unless status is 0.
//   Reset: frame restarts with byte count 0 and CRC 0xFFFF; both registers
//   are empty.
//   Receiver stall: the response register holds; bytes that give no response
//   keep flowing, and req_stall rises only when a response-bearing request
//   waits behind a held response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "modbus_meter_response_checker_assert.svh"

module modbus_meter_response_checker
	import mmrc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        req_type,
	input  wire logic [7:0]  rx_byte,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic      [1:0]  status,
	output logic             reading_valid,
	output logic      [15:0] voltage_raw,
	output logic      [31:0] current_raw,
	output logic      [31:0] power_raw,
	output logic      [31:0] energy_raw,
	output logic      [15:0] frequency_raw,
	output logic      [15:0] pf_raw
);

	// input register
	logic       valid_s1;
	logic       req_type_s1;
	logic [7:0] rx_byte_s1;

	// result register
	logic    valid_s2;
	result_t result_s2;

	logic      adv;
	logic      has_result;
	frame_in_t fin;
	result_t   res;

	// Advance the input stage unless its request needs the result register
	// and that register holds a response the receiver is stalling.
	assign adv       = valid_s1 && (!has_result || !valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !adv;

	assign fin.step     = adv;
	assign fin.req_type = req_type_s1;
	assign fin.rx_byte  = rx_byte_s1;

	mmrc_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.fin        (fin),
		.has_result (has_result),
		.res        (res)
	);

	// Load a new request whenever the input stage is free or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_type_s1 <= req_type;
			rx_byte_s1  <= rx_byte;
		end
	end

	// Capture a response on advance; drop it once the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && has_result) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			result_s2 <= res;
		end
	end

	assign rsp_valid     = valid_s2;
	assign status        = result_s2.status;
	assign reading_valid = result_s2.reading_valid;
	assign voltage_raw   = result_s2.voltage_raw;
	assign current_raw   = result_s2.current_raw;
	assign power_raw     = result_s2.power_raw;
	assign energy_raw    = result_s2.energy_raw;
	assign frequency_raw = result_s2.frequency_raw;
	assign pf_raw        = result_s2.pf_raw;

	// A response only appears after a response-bearing request advanced.
	`MMRC_AST_IMPLY(a_rsp_source, clk, arst_n, $rose(rsp_valid), $past(adv && has_result))
	// A timeout request always yields a timeout response next cycle.
	`MMRC_AST_NEXT(a_timeout_rsp, clk, arst_n, adv && (req_type_s1 == REQ_TIMEOUT), rsp_valid && (status == ST_TIMEOUT))
	// Readings are flagged valid exactly for a good frame.
	`MMRC_AST_IMPLY(a_reading_flag, clk, arst_n, rsp_valid, reading_valid == (status == ST_OK))
	// Back-pressure only from a held response blocking a new one.
	`MMRC_AST_IMPLY(a_stall_cause, clk, arst_n, req_stall, valid_s1 && has_result && rsp_valid && rsp_stall)

endmodule

`default_nettype wire

// ===== hw/rtl/mmrc_crc16.sv =====
// ----------------------------------------------------------------------------
// mmrc_crc16
// One-byte update of a reflected CRC-16/Modbus, eight shift steps unrolled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmrc_crc16
	import mmrc_pkg::*;
(
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mmrc_frame.sv =====
// ----------------------------------------------------------------------------
// mmrc_frame
// Frame state: byte count, running CRC and byte store; builds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmrc_frame
	import mmrc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire frame_in_t fin,
	output logic           has_result,
	output result_t        res
);

	logic [CNT_W-1:0] count_q;
	logic [15:0]      crc_q;
	logic [7:0]       store_q [FRAME_BYTES];

	logic        last;
	logic        is_timeout;
	logic [15:0] crc_next;
	logic [15:0] got;

	mmrc_crc16 u_crc (
		.crc_in  (crc_q),
		.data    (fin.rx_byte),
		.crc_out (crc_next)
	);

	assign last       = (count_q == CNT_W'(FRAME_BYTES - 1));
	assign is_timeout = (fin.req_type == REQ_TIMEOUT);
	assign has_result = is_timeout || last;
	// CRC trailer: byte 23 low, byte 24 (the one arriving now) high
	assign got        = {fin.rx_byte, store_q[CRC_SPAN]};

	always_comb begin
		res = '0;
		if (is_timeout) begin
			res.status = ST_TIMEOUT;
		end else if (got != crc_q) begin
			res.status = ST_CRC;
		end else begin
			res.status        = ST_OK;
			res.reading_valid = 1'b1;
			res.voltage_raw   = {store_q[3], store_q[4]};
			res.current_raw   = {store_q[7], store_q[8], store_q[5], store_q[6]};
			res.power_raw     = {store_q[11], store_q[12], store_q[9], store_q[10]};
			res.energy_raw    = {store_q[15], store_q[16], store_q[13], store_q[14]};
			res.frequency_raw = {store_q[17], store_q[18]};
			res.pf_raw        = {store_q[19], store_q[20]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= CRC_INIT;
		end else if (fin.step) begin
			if (has_result) begin
				count_q <= '0;
				crc_q   <= CRC_INIT;
			end else begin
				count_q <= count_q + CNT_W'(1);
				if (count_q < CNT_W'(CRC_SPAN)) begin
					crc_q <= crc_next;
				end
			end
		end
	end

	// Byte store: every received byte, no reset
	always_ff @(posedge clk) begin
		if (fin.step && !is_timeout) begin
			store_q[count_q] <= fin.rx_byte;
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Modbus meter reply checker. The bench feeds
// reply frames one UART byte per request, together with corrupted frames,
// short frames cut off by a timeout, and stray bytes. A local model keeps the
// same frame state and checks every response field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import mmrc_pkg::*;

	localparam int RANDOM_ITEMS = 1850;
	localparam int SPARSE_IDLE  = 10;     // percent of cycles spent idle
	localparam int HEAVY_IDLE   = 86;
	localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
	localparam int DRAIN_CYCLES = 10;     // slack after the last response
	localparam int LIMIT_CYCLES = 400000;

	// One request as the sender queues it: a UART byte or a reply timeout.
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
	} uart_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        req_type = REQ_BYTE;
	logic [7:0]  rx_byte = 8'h00;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [1:0]  status;
	logic        reading_valid;
	logic [15:0] voltage_raw;
	logic [31:0] current_raw;
	logic [31:0] power_raw;
	logic [31:0] energy_raw;
	logic [15:0] frequency_raw;
	logic [15:0] pf_raw;

	// Requests waiting for the sender, and replies the model has worked out.
	uart_req_t pending_reqs[$];
	result_t   expected_replies[$];

	// Model copy of the frame state.
	logic [4:0]  frame_len = '0;
	logic [15:0] frame_crc = CRC_INIT;
	logic [7:0]  frame_bytes[FRAME_BYTES];

	int total_reqs = 0;
	int issued_cnt = 0;
	int cycle_cnt  = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	int err_cnt    = 0;
	int good_cnt   = 0;
	int crc_err_cnt = 0;
	int timeout_cnt = 0;

	modbus_meter_response_checker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.rx_byte       (rx_byte),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.reading_valid (reading_valid),
		.voltage_raw   (voltage_raw),
		.current_raw   (current_raw),
		.power_raw     (power_raw),
		.energy_raw    (energy_raw),
		.frequency_raw (frequency_raw),
		.pf_raw        (pf_raw)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	// CRC-16/Modbus over one byte, LSB first with the reflected polynomial.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Advance the frame state by one accepted request and queue the reply it
	// causes, if any.
	task automatic absorb_request(input logic kind, input logic [7:0] b);
		result_t rep;
		rep = '0;
		if (kind == REQ_TIMEOUT) begin
			// Timeout: drop the partial frame, rx_byte plays no part.
			frame_len = '0;
			frame_crc = CRC_INIT;
			rep.status = ST_TIMEOUT;
			expected_replies.push_back(rep);
		end else begin
			frame_bytes[frame_len] = b;
			if (frame_len < CRC_SPAN)
				frame_crc = crc16_byte(frame_crc, b);
			frame_len = frame_len + 1'b1;
			if (frame_len == FRAME_BYTES) begin
				if ({frame_bytes[24], frame_bytes[23]} != frame_crc) begin
					rep.status = ST_CRC;
				end else begin
					// Words are big-endian; 32-bit values put the low word first.
					rep.status        = ST_OK;
					rep.reading_valid = 1'b1;
					rep.voltage_raw   = {frame_bytes[3], frame_bytes[4]};
					rep.current_raw   = {frame_bytes[7], frame_bytes[8],
						frame_bytes[5], frame_bytes[6]};
					rep.power_raw     = {frame_bytes[11], frame_bytes[12],
						frame_bytes[9], frame_bytes[10]};
					rep.energy_raw    = {frame_bytes[15], frame_bytes[16],
						frame_bytes[13], frame_bytes[14]};
					rep.frequency_raw = {frame_bytes[17], frame_bytes[18]};
					rep.pf_raw        = {frame_bytes[19], frame_bytes[20]};
				end
				expected_replies.push_back(rep);
				frame_len = '0;
				frame_crc = CRC_INIT;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------

	task automatic queue_req(input logic kind, input logic [7:0] b);
		uart_req_t r;
		r.kind = kind;
		r.data = b;
		pending_reqs.push_back(r);
	endtask

	// Queue one whole 25-byte reply. fill: 0 random readings, 1 all zero,
	// 2 all ones. With corrupt set, flip one bit anywhere in the frame.
	task automatic queue_frame(input int fill, input bit corrupt);
		logic [7:0]  fr[FRAME_BYTES];
		logic [15:0] crc;
		int          pos;
		crc = CRC_INIT;
		fr[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h01;
		fr[1] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h04;
		fr[2] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h14;
		for (int i = 3; i < CRC_SPAN; i++)
			fr[i] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
		for (int i = 0; i < CRC_SPAN; i++)
			crc = crc16_byte(crc, fr[i]);
		fr[23] = crc[7:0];
		fr[24] = crc[15:8];
		if (corrupt) begin
			pos = $urandom_range(0, FRAME_BYTES - 1);
			fr[pos] = fr[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
		for (int i = 0; i < FRAME_BYTES; i++)
			queue_req(REQ_BYTE, fr[i]);
	endtask

	// ------------------------------------------------------------------
	// Idling schedule: sender light / receiver heavy, then the reverse,
	// then no idling at all.
	// ------------------------------------------------------------------

	function automatic int sender_idle_pct();
		if (issued_cnt < total_reqs / 3)
			return SPARSE_IDLE;
		if (issued_cnt < 2 * total_reqs / 3)
			return HEAVY_IDLE;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (issued_cnt < total_reqs / 3)
			return HEAVY_IDLE;
		if (issued_cnt < 2 * total_reqs / 3)
			return SPARSE_IDLE;
		return 0;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)",
			what, got, want, cycle_cnt);
		err_cnt++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Driver: hold the request while stalled, advance on acceptance.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		uart_req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_type  <= REQ_BYTE;
			rx_byte   <= 8'h00;
		end else if (!req_valid || !req_stall) begin
			// The current request (if any) goes in at this edge: let the
			// model see it before choosing the next one.
			if (req_valid)
				absorb_request(req_type, rx_byte);
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
				nxt = pending_reqs.pop_front();
				req_valid <= 1'b1;
				req_type  <= nxt.kind;
				rx_byte   <= nxt.data;
				issued_cnt++;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off once the sender runs flat out, so that a
	// response sits in the block and a later frame end backs up the input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && total_reqs != 0 && issued_cnt >= 4 * total_reqs / 5) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each accepted response with the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("response with none expected, status",
						32'(status), '0);
				end else begin
					want = expected_replies.pop_front();
					check_field("status", 32'(status), 32'(want.status));
					check_field("reading_valid", 32'(reading_valid),
						32'(want.reading_valid));
					check_field("voltage_raw", 32'(voltage_raw), 32'(want.voltage_raw));
					check_field("current_raw", current_raw, want.current_raw);
					check_field("power_raw", power_raw, want.power_raw);
					check_field("energy_raw", energy_raw, want.energy_raw);
					check_field("frequency_raw", 32'(frequency_raw),
						32'(want.frequency_raw));
					check_field("pf_raw", 32'(pf_raw), 32'(want.pf_raw));
					case (want.status)
						ST_OK:      good_cnt++;
						ST_CRC:     crc_err_cnt++;
						default:    timeout_cnt++;
					endcase
				end
			end
			rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < receiver_idle_pct());
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_cnt, expected_replies.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: build all requests, reset, wait for drain, report.
	// ------------------------------------------------------------------
	initial begin
		int pick;
		int short_len;
		int noise_len;

		// Directed: timeout on an empty frame, timeout after a few bytes
		// with rx_byte set (ignored), and a clean frame of all-ones readings.
		queue_req(REQ_TIMEOUT, 8'h00);
		queue_req(REQ_BYTE, 8'h01);
		queue_req(REQ_BYTE, 8'h04);
		queue_req(REQ_TIMEOUT, 8'hFF);
		queue_frame(2, 1'b0);

		// Random: mostly well-formed replies, the rest corrupted replies,
		// short frames ended by a timeout, and stray byte runs.
		while (pending_reqs.size() < RANDOM_ITEMS + 29) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				queue_frame(0, 1'b0);
			end else if (pick < 65) begin
				queue_frame($urandom_range(1, 2), 1'b0);
			end else if (pick < 80) begin
				queue_frame($urandom_range(0, 2), 1'b1);
			end else if (pick < 92) begin
				short_len = $urandom_range(0, FRAME_BYTES - 1);
				for (int i = 0; i < short_len; i++)
					queue_req(REQ_BYTE, 8'($urandom));
				queue_req(REQ_TIMEOUT, 8'($urandom));
			end else begin
				noise_len = $urandom_range(1, 30);
				for (int i = 0; i < noise_len; i++)
					queue_req(REQ_BYTE, 8'($urandom));
			end
		end
		// Close any frame left open by noise so every byte gets exercised.
		queue_req(REQ_TIMEOUT, 8'h5A);
		total_reqs = pending_reqs.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_replies.size() != 0) begin
			$display("%0d expected responses never arrived", expected_replies.size());
			err_cnt++;
		end
		$display("Sent %0d requests; checked %0d clean frames, %0d CRC failures, %0d timeouts.",
			total_reqs, good_cnt, crc_err_cnt, timeout_cnt);
		$display("Idling phases plus a %0d-cycle response hold-off were covered; %0d mismatches.",
			HOLD_CYCLES, err_cnt);
		if (err_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
